### sv/scru_pkg.sv
package scru_pkg;

  localparam int MW = 33;
  localparam int PW = 66;
  localparam int RW = 23;
  localparam int HW = 16;
  localparam int NW = 64;
  localparam int QW = 32;

  localparam logic [1:0] MODE_OBJECT = 2'd0;
  localparam logic [1:0] MODE_CLIFF  = 2'd1;
  localparam logic [1:0] MODE_RESET  = 2'd2;

  localparam logic [2:0] OC_UNCHANGED = 3'd0;
  localparam logic [2:0] OC_GROWN     = 3'd1;
  localparam logic [2:0] OC_SHRUNK    = 3'd2;
  localparam logic [2:0] OC_SHIFTED   = 3'd3;
  localparam logic [2:0] OC_CLIPPED   = 3'd4;
  localparam logic [2:0] OC_NEG_OPND  = 3'd5;
  localparam logic [2:0] OC_NO_ROOT   = 3'd6;
  localparam logic [2:0] OC_RESET     = 3'd7;

  localparam logic [0:0] REG_DEFAULT_RADIUS = 1'b0;
  localparam logic [0:0] REG_MAX_SHIFT      = 1'b1;

  localparam logic [RW-1:0] R_MAX = 23'h7FFFFF;

  function automatic logic [31:0] poly_coef(input logic [2:0] k);
    logic [31:0] v;
    case (k)
      3'd0: v = 32'd1686629713;
      3'd1: v = 32'd693598668;
      3'd2: v = 32'd85569306;
      3'd3: v = 32'd5026995;
      3'd4: v = 32'd172272;
      3'd5: v = 32'd3864;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Divide by 2^30, rounding half away from zero.
  function automatic logic signed [36:0] rnd30(input logic signed [PW-1:0] v);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    r = (m + (PW'(1) << 29)) >> 30;
    return v[PW-1] ? -$signed(r[36:0]) : $signed(r[36:0]);
  endfunction

endpackage

### sv/scru_in_if.sv
interface scru_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [15:0]                  heading;
  modport source (output valid, mode, point_x, point_y, heading, input ready);
  modport sink (input valid, mode, point_x, point_y, heading, output ready);
endinterface

### sv/scru_out_if.sv
interface scru_out_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x_out;
  logic signed [COORD_BITS-1:0] center_y_out;
  logic [22:0]                  radius_out;
  logic [2:0]                   outcome;
  modport source (output valid, center_x_out, center_y_out, radius_out, outcome,
                  input ready);
  modport sink (input valid, center_x_out, center_y_out, radius_out, outcome,
                output ready);
endinterface

### sv/scru_sqrt.sv
module scru_sqrt
  import scru_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] radicand,
  output logic          done,
  output logic [QW-1:0] root
);

  logic [NW-1:0] v;
  logic [35:0]   rem;
  logic [4:0]    cnt;
  logic          busy;
  logic [35:0]   remn;
  logic [35:0]   trial;

  assign remn  = {rem[33:0], v[NW-1:NW-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        if (remn >= trial) begin
          rem  <= remn - trial;
          root <= {root[QW-2:0], 1'b1};
        end else begin
          rem  <= remn;
          root <= {root[QW-2:0], 1'b0};
        end
        v   <= v << 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/scru_div.sv
module scru_div
  import scru_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [QW:0]   denom,
  output logic          done,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] nq;
  logic [QW:0]   den;
  logic [QW:0]   rem;
  logic [5:0]    cnt;
  logic          busy;
  logic [QW+1:0] remn;
  logic [QW+1:0] diff;

  assign remn = {rem, nq[NW-1]};
  assign diff = remn - {1'b0, den};
  assign quo  = nq[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nq   <= numer;
        den  <= denom;
        rem  <= '0;
      end else if (busy) begin
        if (remn >= {1'b0, den}) begin
          rem <= diff[QW:0];
          nq  <= {nq[NW-2:0], 1'b1};
        end else begin
          rem <= remn[QW:0];
          nq  <= {nq[NW-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/safe_circle_region_update.sv
// Object events run a 32-step square root and two 64-step divisions.
// Cliff events use the shared 33x33 multiplier to evaluate sine and cosine, and a
// 32-step square root. Other events use neither.
// One item is processed at a time; the result waits in an output register.
// Synchronous reset puts the center at zero, the radius and default radius at 4000
// and the largest shift at 1600.
module safe_circle_region_update
  import scru_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [RW-1:0]   cfg_data,
  scru_in_if.sink         in_ch,
  scru_out_if.source      out_ch
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 1;

  typedef enum logic [32:0] {
    S_IDLE = 33'd1 << 0,  S_DIFF = 33'd1 << 1,  S_MX   = 33'd1 << 2,
    S_MY   = 33'd1 << 3,  S_RR   = 33'd1 << 4,  S_DR   = 33'd1 << 5,
    S_CMP  = 33'd1 << 6,  S_SQ1  = 33'd1 << 7,  S_OX   = 33'd1 << 8,
    S_OXD  = 33'd1 << 9,  S_DIVX = 33'd1 << 10, S_OY   = 33'd1 << 11,
    S_OYD  = 33'd1 << 12, S_DIVY = 33'd1 << 13, S_OUPD = 33'd1 << 14,
    S_T2   = 33'd1 << 15, S_T2W  = 33'd1 << 16, S_PM   = 33'd1 << 17,
    S_PA   = 33'd1 << 18, S_PT   = 33'd1 << 19, S_PE   = 33'd1 << 20,
    S_R1   = 33'd1 << 21, S_R2   = 33'd1 << 22, S_R3   = 33'd1 << 23,
    S_R4   = 33'd1 << 24, S_R5   = 33'd1 << 25, S_R6   = 33'd1 << 26,
    S_SQ2  = 33'd1 << 27, S_SEL  = 33'd1 << 28, S_C1   = 33'd1 << 29,
    S_C2   = 33'd1 << 30, S_C3   = 33'd1 << 31, S_DONE = 33'd1 << 32
  } state_t;

  state_t state;

  logic [RW-1:0]        dr;
  logic [RW-1:0]        ms;
  logic signed [CB-1:0] cx;
  logic signed [CB-1:0] cy;
  logic [RW-1:0]        rad;

  logic [1:0]           mode;
  logic signed [CB-1:0] px;
  logic signed [CB-1:0] py;
  logic [HW-1:0]        hd;

  logic signed [31:0]   dx;
  logic signed [31:0]   dy;
  logic [30:0]          mx;
  logic [30:0]          my;
  logic [NW-1:0]        acc;
  logic [45:0]          rsq;
  logic [45:0]          rr2;
  logic [QW-1:0]        d;
  logic [QW-1:0]        num;
  logic [QW-1:0]        qx;
  logic                 qsel;
  logic [30:0]          t2;
  logic [31:0]          p;
  logic [2:0]           k;
  logic [30:0]          sp;
  logic signed [31:0]   s;
  logic signed [31:0]   c;
  logic signed [PW-1:0] tprod;
  logic signed [36:0]   x;
  logic signed [36:0]   y;
  logic [RW-1:0]        shift;
  logic [2:0]           oc;

  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic                 sq_start;
  logic [NW-1:0]        sq_in;
  logic                 sq_done;
  logic [QW-1:0]        sq_root;
  logic                 div_start;
  logic [NW-1:0]        div_num;
  logic                 div_done;
  logic [QW-1:0]        div_quo;

  logic signed [31:0]   dxc;
  logic signed [31:0]   dyc;
  logic [14:0]          f_eff;
  logic [30:0]          t;
  logic [30:0]          pcl;
  logic [36:0]          xm;
  logic signed [37:0]   a1;
  logic signed [37:0]   a2;
  logic [32:0]          nr;

  function automatic logic signed [31:0] clamp_diff(input logic signed [EW-1:0] v);
    logic signed [33:0] w;
    logic signed [31:0] r;
    w = 34'(v);
    if (w > 34'sd2147483647) r = 32'sd2147483647;
    else if (w < -34'sd2147483647) r = -32'sd2147483647;
    else r = w[31:0];
    return r;
  endfunction

  function automatic logic signed [CB-1:0] sat_coord(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = (40'sd1 <<< (CB - 1)) - 40'sd1;
    lo = -hi - 40'sd1;
    if (v > hi) return hi[CB-1:0];
    if (v < lo) return lo[CB-1:0];
    return v[CB-1:0];
  endfunction

  scru_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root)
  );

  scru_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_num),
    .denom({d, 1'b0}), .done(div_done), .quo(div_quo)
  );

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    if (mode == MODE_OBJECT) begin
      dxc = clamp_diff(EW'(px) - EW'(cx));
      dyc = clamp_diff(EW'(py) - EW'(cy));
    end else begin
      dxc = clamp_diff(EW'(cx) - EW'(px));
      dyc = clamp_diff(EW'(cy) - EW'(py));
    end
  end

  assign f_eff = qsel ? (15'd16384 - {1'b0, hd[13:0]}) : {1'b0, hd[13:0]};
  assign t     = {f_eff, 16'b0};
  assign pcl   = (prod[65:30] > 36'd1073741824) ? 31'h40000000 : prod[60:30];
  assign xm    = x[36] ? 37'(-x) : 37'(x);
  assign a1    = -38'(y) + $signed({6'b0, sq_root});
  assign a2    = -38'(y) - $signed({6'b0, sq_root});
  assign nr    = ({1'b0, d} + {10'b0, rad} + 33'd1) >> 1;

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    sq_in     = acc;
    div_start = 1'b0;
    div_num   = prod[NW-1:0] + {32'b0, d};
    case (state)
      S_MX: begin
        mul_a = $signed({2'b0, mx});
        mul_b = $signed({2'b0, mx});
      end
      S_MY: begin
        mul_a = $signed({2'b0, my});
        mul_b = $signed({2'b0, my});
      end
      S_RR: begin
        mul_a = $signed({10'b0, rad});
        mul_b = $signed({10'b0, rad});
      end
      S_DR: begin
        mul_a = $signed({10'b0, dr});
        mul_b = $signed({10'b0, dr});
      end
      S_CMP: begin
        sq_start = (mode == MODE_OBJECT) && (rsq < acc);
      end
      S_OX: begin
        mul_a = $signed({2'b0, mx});
        mul_b = $signed({1'b0, num});
      end
      S_OY: begin
        mul_a = $signed({2'b0, my});
        mul_b = $signed({1'b0, num});
      end
      S_OXD, S_OYD: div_start = 1'b1;
      S_T2: begin
        mul_a = $signed({2'b0, t});
        mul_b = $signed({2'b0, t});
      end
      S_PM: begin
        mul_a = $signed({1'b0, p});
        mul_b = $signed({2'b0, t2});
      end
      S_PT: begin
        mul_a = $signed({1'b0, p});
        mul_b = $signed({2'b0, t});
      end
      S_R1: begin
        mul_a = 33'(dx);
        mul_b = 33'(c);
      end
      S_R2: begin
        mul_a = 33'(dy);
        mul_b = 33'(s);
      end
      S_R3: begin
        mul_a = 33'(dx);
        mul_b = 33'(s);
      end
      S_R4: begin
        mul_a = 33'(dy);
        mul_b = 33'(c);
      end
      S_R5: begin
        mul_a = $signed({1'b0, xm[31:0]});
        mul_b = $signed({1'b0, xm[31:0]});
      end
      S_R6: begin
        sq_in    = {18'b0, rr2 - prod[45:0]};
        sq_start = (xm <= {14'b0, dr});
      end
      S_C1: begin
        mul_a = $signed({10'b0, shift});
        mul_b = 33'(c);
      end
      S_C2: begin
        mul_a = $signed({10'b0, shift});
        mul_b = 33'(s);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dr           <= 23'd4000;
      ms           <= 23'd1600;
      cx           <= '0;
      cy           <= '0;
      rad          <= 23'd4000;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEFAULT_RADIUS: dr <= cfg_data;
          REG_MAX_SHIFT:      ms <= cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready && state != S_DONE) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode  <= in_ch.mode;
            px    <= in_ch.point_x;
            py    <= in_ch.point_y;
            hd    <= in_ch.heading;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          dx <= dxc;
          dy <= dyc;
          mx <= dxc[31] ? 31'(-dxc) : dxc[30:0];
          my <= dyc[31] ? 31'(-dyc) : dyc[30:0];
          if (mode == MODE_OBJECT || mode == MODE_CLIFF) begin
            state <= S_MX;
          end else if (mode == MODE_RESET) begin
            cx    <= px;
            cy    <= py;
            rad   <= dr;
            oc    <= OC_RESET;
            state <= S_DONE;
          end else begin
            oc    <= OC_UNCHANGED;
            state <= S_DONE;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          acc   <= prod[NW-1:0];
          state <= S_RR;
        end
        S_RR: begin
          acc   <= acc + prod[NW-1:0];
          state <= S_DR;
        end
        S_DR: begin
          rsq   <= prod[45:0];
          state <= S_CMP;
        end
        S_CMP: begin
          rr2 <= prod[45:0];
          if (mode == MODE_OBJECT) begin
            if (rsq >= acc) begin
              oc    <= OC_UNCHANGED;
              state <= S_DONE;
            end else begin
              state <= S_SQ1;
            end
          end else if (rsq <= acc) begin
            oc    <= OC_UNCHANGED;
            state <= S_DONE;
          end else if (acc > {18'b0, prod[45:0]}) begin
            rad   <= dr;
            oc    <= OC_SHRUNK;
            state <= S_DONE;
          end else begin
            qsel  <= 1'b0;
            state <= S_T2;
          end
        end
        S_SQ1: begin
          if (sq_done) begin
            d     <= sq_root;
            num   <= sq_root - {9'b0, rad};
            state <= S_OX;
          end
        end
        S_OX: state <= S_OXD;
        S_OXD: state <= S_DIVX;
        S_DIVX: begin
          if (div_done) begin
            qx    <= div_quo;
            state <= S_OY;
          end
        end
        S_OY: state <= S_OYD;
        S_OYD: state <= S_DIVY;
        S_DIVY: begin
          if (div_done) state <= S_OUPD;
        end
        S_OUPD: begin
          cx <= sat_coord(40'(cx) + (dx[31] ? -$signed({8'b0, qx})
                                             : $signed({8'b0, qx})));
          cy <= sat_coord(40'(cy) + (dy[31] ? -$signed({8'b0, div_quo})
                                             : $signed({8'b0, div_quo})));
          rad   <= (nr > {10'b0, R_MAX}) ? R_MAX : nr[RW-1:0];
          oc    <= OC_GROWN;
          state <= S_DONE;
        end
        S_T2: state <= S_T2W;
        S_T2W: begin
          t2    <= prod[60:30];
          p     <= poly_coef(3'd5);
          k     <= 3'd4;
          state <= S_PM;
        end
        S_PM: state <= S_PA;
        S_PA: begin
          p <= poly_coef(k) - prod[61:30];
          if (k == 3'd0) begin
            state <= S_PT;
          end else begin
            k     <= k - 3'd1;
            state <= S_PM;
          end
        end
        S_PT: state <= S_PE;
        S_PE: begin
          if (!qsel) begin
            sp    <= pcl;
            qsel  <= 1'b1;
            state <= S_T2;
          end else begin
            case (hd[15:14])
              2'd0: begin
                s <= $signed({1'b0, sp});
                c <= $signed({1'b0, pcl});
              end
              2'd1: begin
                s <= $signed({1'b0, pcl});
                c <= -$signed({1'b0, sp});
              end
              2'd2: begin
                s <= -$signed({1'b0, sp});
                c <= -$signed({1'b0, pcl});
              end
              default: begin
                s <= -$signed({1'b0, pcl});
                c <= $signed({1'b0, sp});
              end
            endcase
            state <= S_R1;
          end
        end
        S_R1: state <= S_R2;
        S_R2: begin
          tprod <= prod;
          state <= S_R3;
        end
        S_R3: begin
          x     <= rnd30(tprod - prod);
          state <= S_R4;
        end
        S_R4: begin
          tprod <= prod;
          state <= S_R5;
        end
        S_R5: begin
          y     <= rnd30(tprod + prod);
          state <= S_R6;
        end
        S_R6: begin
          if (xm > {14'b0, dr}) begin
            oc    <= OC_NEG_OPND;
            state <= S_DONE;
          end else begin
            state <= S_SQ2;
          end
        end
        S_SQ2: begin
          if (sq_done) state <= S_SEL;
        end
        S_SEL: begin
          if (a2 > 38'sd0 || a1 > 38'sd0) begin
            if (a2 > 38'sd0) begin
              if (a2 > $signed({15'b0, ms})) begin
                shift <= ms;
                oc    <= OC_CLIPPED;
              end else begin
                shift <= a2[RW-1:0];
                oc    <= OC_SHIFTED;
              end
            end else if (a1 > $signed({15'b0, ms})) begin
              shift <= ms;
              oc    <= OC_CLIPPED;
            end else begin
              shift <= a1[RW-1:0];
              oc    <= OC_SHIFTED;
            end
            state <= S_C1;
          end else begin
            oc    <= OC_NO_ROOT;
            state <= S_DONE;
          end
        end
        S_C1: state <= S_C2;
        S_C2: begin
          cx    <= sat_coord(40'(cx) - 40'(rnd30(prod)));
          state <= S_C3;
        end
        S_C3: begin
          cy    <= sat_coord(40'(cy) - 40'(rnd30(prod)));
          rad   <= dr;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid        <= 1'b1;
            out_ch.center_x_out <= cx;
            out_ch.center_y_out <= cy;
            out_ch.radius_out   <= rad;
            out_ch.outcome      <= oc;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");

  ap_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state != S_IDLE)
    else $error("sequencer stayed idle after a transfer");

  ap_sq_done: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQ1 || state == S_SQ2))
    else $error("square root finished while nobody waits for it");

  ap_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVX || state == S_DIVY))
    else $error("division finished while nobody waits for it");

endmodule
